[hw/rtl/tird_pkg.sv]
// ----------------------------------------------------------------------------
// Tape image record deframer package
// Shared widths, event codes and the item and result types.
// ----------------------------------------------------------------------------
package tird_pkg;

    localparam int LEN_W  = 21;
    localparam int FILE_W = 16;
    localparam int HDR_W  = 32;

    localparam logic [LEN_W-1:0] RECORD_LIMIT = 21'h100000;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 21'h100000;
    localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};
    localparam logic [HDR_W-1:0] LEN_EOM = 32'hFFFF_FFFF;
    localparam logic [HDR_W-1:0] LEN_MARK = 32'h0000_0000;

    typedef enum logic [2:0] {
        EV_PAYLOAD   = 3'd0,
        EV_RECORD_OK = 3'd1,
        EV_MARK      = 3'd2,
        EV_EOM       = 3'd3,
        EV_CLEAN_END = 3'd4,
        EV_TOO_LONG  = 3'd5,
        EV_TRUNCATED = 3'd6,
        EV_MISMATCH  = 3'd7
    } event_kind_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] image_byte;
    } item_t;

    typedef struct packed {
        event_kind_t       event_kind;
        logic [7:0]        payload_byte;
        logic              last_of_record;
        logic [LEN_W-1:0]  record_length;
        logic [FILE_W-1:0] file_index;
        logic              file_open;
        logic              mixed_lengths;
    } result_t;

endpackage

[hw/rtl/tird_in_reg.sv]
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted beat and frees itself in the cycle it is consumed.
// ----------------------------------------------------------------------------
module tird_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tird_pkg::item_t s_item,
    input  logic            take,
    output logic            item_valid,
    output tird_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    tird_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

[hw/rtl/tird_core.sv]
// ----------------------------------------------------------------------------
// Deframer core
// Holds the framing state and turns one item into at most one result.
// ----------------------------------------------------------------------------
module tird_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_write,
    input  logic [tird_pkg::LEN_W-1:0]   cfg_data,
    input  logic                         go,
    input  tird_pkg::item_t              item,
    output logic                         res_valid,
    output tird_pkg::result_t            res
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_PAD,
        PH_TRAILER,
        PH_HALTED
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [1:0]                    count_reg, count_next;
    logic [23:0]                   lead_reg, lead_next;
    logic [23:0]                   trail_reg, trail_next;
    logic [tird_pkg::LEN_W-1:0]    left_reg, left_next;
    logic [tird_pkg::LEN_W-1:0]    first_reg, first_next;
    logic                          have_first_reg, have_first_next;
    logic                          mixed_reg, mixed_next;
    logic [tird_pkg::FILE_W-1:0]   file_reg, file_next;
    logic                          open_reg, open_next;
    logic [tird_pkg::LEN_W-1:0]    max_len_reg;

    logic [tird_pkg::LEN_W-1:0]    limit;
    logic [tird_pkg::HDR_W-1:0]    lead_full;
    logic [tird_pkg::HDR_W-1:0]    trail_full;
    logic [tird_pkg::LEN_W-1:0]    left_dec;
    logic [tird_pkg::LEN_W-1:0]    lead_len;

    assign limit      = (max_len_reg > tird_pkg::RECORD_LIMIT) ? tird_pkg::RECORD_LIMIT
                                                               : max_len_reg;
    assign lead_full  = {item.image_byte, lead_reg};
    assign trail_full = {item.image_byte, trail_reg};
    assign left_dec   = left_reg - {{(tird_pkg::LEN_W-1){1'b0}}, 1'b1};
    assign lead_len   = lead_reg[tird_pkg::LEN_W-1:0];

    always_comb begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        lead_next       = lead_reg;
        trail_next      = trail_reg;
        left_next       = left_reg;
        first_next      = first_reg;
        have_first_next = have_first_reg;
        mixed_next      = mixed_reg;
        file_next       = file_reg;
        open_next       = open_reg;
        res_valid       = 1'b0;
        res.event_kind     = tird_pkg::EV_PAYLOAD;
        res.payload_byte   = 8'd0;
        res.last_of_record = 1'b0;
        res.record_length  = '0;

        if (go && phase_reg != PH_HALTED) begin
            if (item.mode) begin
                phase_next = PH_HALTED;
                res_valid  = 1'b1;
                if (phase_reg == PH_HEADER) begin
                    res.event_kind = tird_pkg::EV_CLEAN_END;
                end else begin
                    res.event_kind    = tird_pkg::EV_TRUNCATED;
                    res.record_length = lead_len;
                end
            end else begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        count_next = count_reg + 2'd1;
                        unique case (count_reg)
                            2'd0: lead_next = {16'd0, item.image_byte};
                            2'd1: lead_next[15:8] = item.image_byte;
                            2'd2: lead_next[23:16] = item.image_byte;
                            default: begin
                                lead_next = lead_full[23:0];
                                res_valid = 1'b1;
                                if (lead_full == tird_pkg::LEN_EOM) begin
                                    phase_next     = PH_HALTED;
                                    res.event_kind = tird_pkg::EV_EOM;
                                end else if (lead_full == tird_pkg::LEN_MARK) begin
                                    res.event_kind = tird_pkg::EV_MARK;
                                    if (open_reg) begin
                                        open_next = 1'b0;
                                        if (file_reg != {tird_pkg::FILE_W{1'b1}}) begin
                                            file_next = file_reg +
                                                {{(tird_pkg::FILE_W-1){1'b0}}, 1'b1};
                                        end
                                    end
                                end else if (lead_full >
                                             {{(tird_pkg::HDR_W-tird_pkg::LEN_W){1'b0}},
                                              limit}) begin
                                    phase_next     = PH_HALTED;
                                    res.event_kind = tird_pkg::EV_TOO_LONG;
                                    if (lead_full[tird_pkg::HDR_W-1:tird_pkg::LEN_W] != '0) begin
                                        res.record_length = tird_pkg::LEN_SAT;
                                    end else begin
                                        res.record_length = lead_full[tird_pkg::LEN_W-1:0];
                                    end
                                end else begin
                                    res_valid  = 1'b0;
                                    left_next  = lead_full[tird_pkg::LEN_W-1:0];
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                        endcase
                    end
                    PH_PAYLOAD: begin
                        left_next          = left_dec;
                        res_valid          = 1'b1;
                        res.payload_byte   = item.image_byte;
                        res.last_of_record = (left_dec == '0);
                        res.record_length  = lead_len;
                        if (left_dec == '0) begin
                            phase_next = lead_reg[0] ? PH_PAD : PH_TRAILER;
                        end
                    end
                    PH_PAD: begin
                        phase_next = PH_TRAILER;
                    end
                    PH_TRAILER: begin
                        count_next = count_reg + 2'd1;
                        unique case (count_reg)
                            2'd0: trail_next = {16'd0, item.image_byte};
                            2'd1: trail_next[15:8] = item.image_byte;
                            2'd2: trail_next[23:16] = item.image_byte;
                            default: begin
                                res_valid         = 1'b1;
                                res.record_length = lead_len;
                                if (trail_full != {8'd0, lead_reg}) begin
                                    phase_next     = PH_HALTED;
                                    res.event_kind = tird_pkg::EV_MISMATCH;
                                end else begin
                                    res.event_kind = tird_pkg::EV_RECORD_OK;
                                    phase_next     = PH_HEADER;
                                    open_next      = 1'b1;
                                    if (!have_first_reg) begin
                                        first_next      = lead_len;
                                        have_first_next = 1'b1;
                                    end else if (lead_len != first_reg) begin
                                        mixed_next = 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                    default: begin
                        phase_next = PH_HALTED;
                    end
                endcase
            end
        end

        res.file_index    = file_next;
        res.file_open     = open_next;
        res.mixed_lengths = mixed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            count_reg      <= 2'd0;
            lead_reg       <= '0;
            trail_reg      <= '0;
            left_reg       <= '0;
            first_reg      <= '0;
            have_first_reg <= 1'b0;
            mixed_reg      <= 1'b0;
            file_reg       <= '0;
            open_reg       <= 1'b0;
            max_len_reg    <= tird_pkg::MAX_LEN_RESET;
        end else begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            lead_reg       <= lead_next;
            trail_reg      <= trail_next;
            left_reg       <= left_next;
            first_reg      <= first_next;
            have_first_reg <= have_first_next;
            mixed_reg      <= mixed_next;
            file_reg       <= file_next;
            open_reg       <= open_next;
            if (cfg_write) begin
                max_len_reg <= cfg_data;
            end
        end
    end

endmodule

[hw/rtl/tird_out_reg.sv]
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module tird_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              go,
    input  logic              res_valid,
    input  tird_pkg::result_t res,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output tird_pkg::result_t m_res
);

    logic              valid_reg;
    logic              valid_next;
    tird_pkg::result_t res_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = free ? (go && res_valid) : valid_reg;
    assign m_valid    = valid_reg;
    assign m_res      = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (free && go && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

[hw/rtl/tape_image_record_deframer.sv]
// ----------------------------------------------------------------------------
// Tape image record deframer
// Splits a byte stream of a tape image into records, marks and end events.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle unless the output is stalled: the
// beat enters an input register, the framing state is updated and the result
// lands in the output register. Header bytes give a result only for a mark, end
// of medium or an oversized length; pad and non-final trailer bytes give none.
// After an error, end of medium or end of image the block ignores every beat
// until reset. The length limit may be written only while no beat is in flight.
module tape_image_record_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // image_byte[7:0]
    input  logic        s_tuser,  // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // payload_byte[7:0], record_length[28:8],
                                  // file_index[44:29], file_open[45],
                                  // mixed_lengths[46], zero[47]
    output logic [2:0]  m_tuser,  // event_kind
    output logic        m_tlast,  // last_of_record
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [20:0] cfg_data  // max_record_length
);

    tird_pkg::item_t   s_item;
    tird_pkg::item_t   item;
    tird_pkg::result_t res;
    tird_pkg::result_t m_res;
    logic              item_valid;
    logic              free;
    logic              go;
    logic              res_valid;

    assign s_item.mode       = s_tuser;
    assign s_item.image_byte = s_tdata;
    assign go                = item_valid && free;
    assign cfg_ready         = 1'b1;

    tird_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .take       (go),
        .item_valid (item_valid),
        .item       (item)
    );

    tird_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid),
        .cfg_data  (cfg_data),
        .go        (go),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    tird_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (go),
        .res_valid (res_valid),
        .res       (res),
        .free      (free),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res)
    );

    assign m_tuser = m_res.event_kind;
    assign m_tlast = m_res.last_of_record;
    assign m_tdata = {1'b0, m_res.mixed_lengths, m_res.file_open, m_res.file_index,
                      m_res.record_length, m_res.payload_byte};

endmodule

[tb/tape_image_record_deframer_tb.sv]
// ----------------------------------------------------------------------------
// Tape image record deframer testbench
// Feeds the deframer a tape image built from marks and well-formed records
// under several length limits, with random gaps on both streams, and checks
// every result beat against a cycle-free model of the framing rules. The
// image ends with one randomly chosen closing case: a clean end, a partial
// length, end of medium, an oversized length, truncation or a length mismatch.
// ----------------------------------------------------------------------------
module tape_image_record_deframer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT = 4000;

    typedef enum logic [2:0] {
        SEEK_LENGTH,
        IN_PAYLOAD,
        AT_PAD,
        IN_TRAILER,
        STOPPED
    } frame_phase_t;

    typedef struct {
        logic              mode;
        logic [7:0]        data;
        bit                typed;
        tird_pkg::result_t want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [20:0] cfg_data  = '0;

    // Model state, starting from the reset values.
    frame_phase_t                frame_phase      = SEEK_LENGTH;
    logic [1:0]                  word_byte_idx    = '0;
    logic [31:0]                 lead_word        = '0;
    logic [31:0]                 trail_word       = '0;
    logic [tird_pkg::LEN_W-1:0]  payload_left     = '0;
    logic [tird_pkg::LEN_W-1:0]  first_record_len = '0;
    bit                          first_seen       = 1'b0;
    bit                          lengths_differ   = 1'b0;
    logic [tird_pkg::FILE_W-1:0] file_number      = '0;
    bit                          file_has_records = 1'b0;
    logic [tird_pkg::LEN_W-1:0]  max_len_reg      = tird_pkg::MAX_LEN_RESET;

    tird_pkg::result_t expected_events[$];
    stim_row_t         opening_rows[22];
    int unsigned       beats_sent  = 0;
    int unsigned       error_count = 0;
    int unsigned       calm_left   = 0;
    int unsigned       sink_hold   = 0;

    tape_image_record_deframer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [tird_pkg::LEN_W-1:0] limit_in_force();
        return (max_len_reg > tird_pkg::RECORD_LIMIT) ? tird_pkg::RECORD_LIMIT
                                                      : max_len_reg;
    endfunction

    function automatic void deframe_beat(input logic mode, input logic [7:0] data,
                                         output bit produced,
                                         output tird_pkg::result_t ev);
        produced = 1'b0;
        ev = '0;
        if (frame_phase == STOPPED) begin
            return;
        end
        if (mode) begin
            ev.event_kind    = (frame_phase == SEEK_LENGTH) ? tird_pkg::EV_CLEAN_END
                                                            : tird_pkg::EV_TRUNCATED;
            ev.record_length = (frame_phase == SEEK_LENGTH) ? '0
                                                            : lead_word[tird_pkg::LEN_W-1:0];
            frame_phase = STOPPED;
            produced = 1'b1;
        end else begin
            case (frame_phase)
                SEEK_LENGTH: begin
                    if (word_byte_idx == 0) lead_word = '0;
                    lead_word[word_byte_idx*8 +: 8] = data;
                    word_byte_idx++;
                    if (word_byte_idx == 0) begin
                        if (lead_word == tird_pkg::LEN_EOM) begin
                            frame_phase = STOPPED;
                            ev.event_kind = tird_pkg::EV_EOM;
                            produced = 1'b1;
                        end else if (lead_word == tird_pkg::LEN_MARK) begin
                            if (file_has_records) begin
                                if (file_number != '1) file_number++;
                                file_has_records = 1'b0;
                            end
                            ev.event_kind = tird_pkg::EV_MARK;
                            produced = 1'b1;
                        end else if (lead_word > 32'(limit_in_force())) begin
                            frame_phase = STOPPED;
                            ev.event_kind = tird_pkg::EV_TOO_LONG;
                            ev.record_length = (lead_word > 32'(tird_pkg::LEN_SAT)) ?
                                               tird_pkg::LEN_SAT :
                                               lead_word[tird_pkg::LEN_W-1:0];
                            produced = 1'b1;
                        end else begin
                            payload_left = lead_word[tird_pkg::LEN_W-1:0];
                            frame_phase = IN_PAYLOAD;
                        end
                    end
                end
                IN_PAYLOAD: begin
                    if (payload_left != 0) payload_left--;
                    if (payload_left == 0) begin
                        frame_phase = lead_word[0] ? AT_PAD : IN_TRAILER;
                    end
                    ev.event_kind     = tird_pkg::EV_PAYLOAD;
                    ev.payload_byte   = data;
                    ev.last_of_record = (payload_left == 0);
                    ev.record_length  = lead_word[tird_pkg::LEN_W-1:0];
                    produced = 1'b1;
                end
                AT_PAD: begin
                    frame_phase = IN_TRAILER;
                end
                IN_TRAILER: begin
                    if (word_byte_idx == 0) trail_word = '0;
                    trail_word[word_byte_idx*8 +: 8] = data;
                    word_byte_idx++;
                    if (word_byte_idx == 0) begin
                        ev.record_length = lead_word[tird_pkg::LEN_W-1:0];
                        produced = 1'b1;
                        if (trail_word != lead_word) begin
                            frame_phase = STOPPED;
                            ev.event_kind = tird_pkg::EV_MISMATCH;
                        end else begin
                            if (!first_seen) begin
                                first_record_len = lead_word[tird_pkg::LEN_W-1:0];
                                first_seen = 1'b1;
                            end else if (lead_word[tird_pkg::LEN_W-1:0] !=
                                         first_record_len) begin
                                lengths_differ = 1'b1;
                            end
                            file_has_records = 1'b1;
                            frame_phase = SEEK_LENGTH;
                            ev.event_kind = tird_pkg::EV_RECORD_OK;
                        end
                    end
                end
                default: begin
                    frame_phase = STOPPED;
                end
            endcase
        end
        ev.file_index    = file_number;
        ev.file_open     = file_has_records;
        ev.mixed_lengths = lengths_differ;
    endfunction

    function automatic stim_row_t image_row(input logic [7:0] d);
        stim_row_t row;
        row.mode  = 1'b0;
        row.data  = d;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic stim_row_t event_row(input logic [7:0] d,
                                            input tird_pkg::event_kind_t k,
                                            input logic [7:0] pb, input logic last,
                                            input logic [tird_pkg::LEN_W-1:0] len,
                                            input logic [tird_pkg::FILE_W-1:0] fidx,
                                            input logic fopen, input logic mixed);
        stim_row_t row;
        row.mode  = 1'b0;
        row.data  = d;
        row.typed = 1'b1;
        row.want  = '{event_kind: k, payload_byte: pb, last_of_record: last,
                      record_length: len, file_index: fidx, file_open: fopen,
                      mixed_lengths: mixed};
        return row;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_left != 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic int unsigned pick_length(input int unsigned lim);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0 && lim <= 300) return lim;
        if (r < 3) return $urandom_range(1, (lim < 300) ? lim : 300);
        return $urandom_range(1, (lim < 24) ? lim : 24);
    endfunction

    task automatic feed_beat(input logic mode, input logic [7:0] data,
                             input bit typed = 1'b0,
                             input tird_pkg::result_t want = '0);
        bit                produced;
        tird_pkg::result_t ev;
        int unsigned       gap;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        deframe_beat(mode, data, produced, ev);
        if (typed) begin
            expected_events.push_back(want);
        end else if (produced) begin
            expected_events.push_back(ev);
        end
        beats_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            feed_beat(1'b0, w[i*8 +: 8]);
        end
    endtask

    task automatic send_body(input int unsigned n);
        repeat (n) feed_beat(1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_record(input int unsigned len);
        send_word(32'(len));
        send_body(len);
        if (len % 2 == 1) feed_beat(1'b0, 8'($urandom_range(0, 255)));
        send_word(32'(len));
    endtask

    task automatic write_max_length(input logic [tird_pkg::LEN_W-1:0] value);
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        max_len_reg = value;
    endtask

    task automatic run_phase(input logic [tird_pkg::LEN_W-1:0] value,
                             input int unsigned n_beats);
        int unsigned start;
        int unsigned lim;
        write_max_length(value);
        start = beats_sent;
        lim = limit_in_force();
        while (beats_sent - start < n_beats) begin
            if (lim == 0 || $urandom_range(0, 7) < 2) begin
                send_word(tird_pkg::LEN_MARK);
                if ($urandom_range(0, 3) == 0) send_word(tird_pkg::LEN_MARK);
            end else begin
                send_record(pick_length(lim));
            end
        end
    endtask

    // Exactly one halting case per run, since the block stays halted until reset.
    task automatic finish_image();
        int unsigned lim;
        int unsigned len;
        logic [31:0] tl;
        lim = limit_in_force();
        len = pick_length(lim);
        case ($urandom_range(0, 6))
            0: begin
                feed_beat(1'b1, 8'($urandom_range(0, 255)));
            end
            1: begin
                send_body($urandom_range(1, 3));
                feed_beat(1'b1, 8'($urandom_range(0, 255)));
            end
            2: begin
                send_word(tird_pkg::LEN_EOM);
            end
            3: begin
                case ($urandom_range(0, 2))
                    0: tl = 32'(lim) + 32'd1;
                    1: tl = $urandom_range(lim + 1, 32'h001F_FFFF);
                    default: tl = $urandom_range(32'h0020_0000, 32'hFFFF_FFFE);
                endcase
                send_word(tl);
            end
            4: begin
                send_word(32'(len));
                send_body($urandom_range(0, len - 1));
                feed_beat(1'b1, 8'($urandom_range(0, 255)));
            end
            5: begin
                send_word(32'(len));
                send_body(len);
                send_body($urandom_range(0, 3 + len % 2));
                feed_beat(1'b1, 8'($urandom_range(0, 255)));
            end
            default: begin
                send_word(32'(len));
                send_body(len);
                if (len % 2 == 1) feed_beat(1'b0, 8'($urandom_range(0, 255)));
                send_word(32'(len) ^ (32'd1 << $urandom_range(0, 31)));
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (error_count < 40) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : sink_pacing
        int unsigned r;
        if (sink_hold != 0) begin
            sink_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                m_tready <= 1'b1;
                sink_hold = $urandom_range(0, 6);
            end else if (r < 60) begin
                m_tready <= 1'b1;
                sink_hold = $urandom_range(30, 120);
            end else if (r < 92) begin
                m_tready <= 1'b0;
                sink_hold = $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b0;
                sink_hold = $urandom_range(15, 60);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        tird_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                if (error_count < 40) begin
                    $display("%0t: result beat with none expected, event %0d",
                             $time, m_tuser);
                end
                error_count++;
            end else begin
                want = expected_events.pop_front();
                check_field("event_kind", 32'(want.event_kind), 32'(m_tuser));
                check_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[7:0]));
                check_field("last_of_record", 32'(want.last_of_record), 32'(m_tlast));
                check_field("record_length", 32'(want.record_length), 32'(m_tdata[28:8]));
                check_field("file_index", 32'(want.file_index), 32'(m_tdata[44:29]));
                check_field("file_open", 32'(want.file_open), 32'(m_tdata[45]));
                check_field("mixed_lengths", 32'(want.mixed_lengths), 32'(m_tdata[46]));
            end
        end
    end

    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("[tape_image_record_deframer] ERROR");
        $finish;
    end

    initial begin : stimulus
        opening_rows = '{
            image_row(8'h00), image_row(8'h00), image_row(8'h00),
            event_row(8'h00, tird_pkg::EV_MARK, 8'h00, 1'b0, 21'd0, 16'd0, 1'b0, 1'b0),
            image_row(8'h00), image_row(8'h00), image_row(8'h00),
            event_row(8'h00, tird_pkg::EV_MARK, 8'h00, 1'b0, 21'd0, 16'd0, 1'b0, 1'b0),
            image_row(8'h01), image_row(8'h00), image_row(8'h00), image_row(8'h00),
            event_row(8'hFF, tird_pkg::EV_PAYLOAD, 8'hFF, 1'b1, 21'd1, 16'd0, 1'b0, 1'b0),
            image_row(8'h5A),
            image_row(8'h01), image_row(8'h00), image_row(8'h00),
            event_row(8'h00, tird_pkg::EV_RECORD_OK, 8'h00, 1'b0, 21'd1, 16'd0,
                      1'b1, 1'b0),
            image_row(8'h00), image_row(8'h00), image_row(8'h00),
            event_row(8'h00, tird_pkg::EV_MARK, 8'h00, 1'b0, 21'd0, 16'd1, 1'b0, 1'b0)
        };
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (opening_rows[i]) begin
            feed_beat(opening_rows[i].mode, opening_rows[i].data,
                      opening_rows[i].typed, opening_rows[i].want);
        end
        run_phase(21'd1, 120);
        run_phase(21'd0, 20);
        run_phase(tird_pkg::LEN_SAT, 250);
        run_phase(21'($urandom_range(2, 40)), 250);
        run_phase(21'($urandom_range(41, 300)), 250);
        run_phase(($urandom_range(0, 1) != 0) ? tird_pkg::MAX_LEN_RESET :
                  21'($urandom_range(1, 40)), 150);
        finish_image();
        repeat ($urandom_range(2, 5)) begin
            feed_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0 && expected_events.size() == 0) begin
            $display("[tape_image_record_deframer] OK");
        end else begin
            $display("[tape_image_record_deframer] ERROR");
        end
        $finish;
    end

endmodule
